FILE: hw/rtl/xmmct_pkg.sv
// Shared types and constants for the xor-masked mex count tree.
`default_nettype none
package xmmct_pkg;

  localparam int VALUE_W = 16;
  localparam int MEX_W   = 16;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_LEAF,
    ST_INS_WALK,
    ST_Q_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               cmd;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             valid;
    logic [MEX_W-1:0] mex;
    logic             all_present;
  } rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/xmmct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module xmmct_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 131072
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/xmmct_ctrl.sv
// Tree walk sequencer: clear pass, insert climb and masked mex descent.
`default_nettype none
module xmmct_ctrl #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire xmmct_pkg::req_t       req,
  output logic                       ready,
  output xmmct_pkg::rsp_t            rsp,
  input  wire logic                  rsp_take,
  output logic                       wr_en,
  output logic [VALUE_BITS:0]        wr_addr,
  output logic [VALUE_BITS:0]        wr_data,
  output logic                       rd_en,
  output logic [VALUE_BITS:0]        rd_addr,
  input  wire logic [VALUE_BITS:0]   rd_data
);
  import xmmct_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int LW = $clog2(VB);
  localparam int CW = (VB < VALUE_W) ? VB : VALUE_W;
  localparam logic [VB-1:0] NODE_ONE = VB'(1);

  state_t          state_r, state_nxt;
  logic [VB:0]     clr_addr_r, clr_addr_nxt;
  logic [VB:0]     node_r, node_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;
  logic [VB-1:0]   res_r, res_nxt;
  logic            full_r, full_nxt;
  logic [VB-1:0]   mask_r, mask_nxt;
  logic [VB:0]     total_r, total_nxt;

  logic [VB-1:0]   val_in;
  logic [VB:0]     leaf_node;
  logic [VB:0]     parent_node;
  logic [VB:0]     first_child;
  logic [VB:0]     sel_node;
  logic [LW-1:0]   lvl_dec;
  logic [VB-1:0]   mask_upd;

  always_comb begin
    val_in = '0;
    val_in[CW-1:0] = req.value[CW-1:0];
  end

  assign leaf_node   = {1'b1, val_in};
  assign parent_node = {1'b0, node_r[VB:1]};
  assign mask_upd    = mask_r ^ val_in;
  assign first_child = {{(VB-1){1'b0}}, 1'b1, mask_upd[VB-1]};
  assign lvl_dec     = lvl_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      mask_r     <= '0;
      total_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      mask_r     <= mask_nxt;
      total_r    <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    lvl_r  <= lvl_nxt;
    res_r  <= res_nxt;
    full_r <= full_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    node_nxt     = node_r;
    lvl_nxt      = lvl_r;
    res_nxt      = res_r;
    full_nxt     = full_r;
    mask_nxt     = mask_r;
    total_nxt    = total_r;
    sel_node     = node_r;
    wr_en        = 1'b0;
    wr_addr      = node_r;
    wr_data      = rd_data + 1'b1;
    rd_en        = 1'b0;
    rd_addr      = node_r;
    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (req.cmd == CMD_INSERT) begin
            rd_en     = 1'b1;
            rd_addr   = leaf_node;
            node_nxt  = leaf_node;
            state_nxt = ST_INS_LEAF;
          end else begin
            mask_nxt = mask_upd;
            res_nxt  = '0;
            if (total_r[VB]) begin
              full_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              full_nxt  = 1'b0;
              lvl_nxt   = LW'(VB - 1);
              node_nxt  = first_child;
              rd_en     = 1'b1;
              rd_addr   = first_child;
              state_nxt = ST_Q_WALK;
            end
          end
        end
      end
      ST_INS_LEAF: begin
        // leaf already set: duplicate, nothing to update
        if (rd_data != '0) begin
          state_nxt = ST_IDLE;
        end else begin
          wr_en     = 1'b1;
          total_nxt = total_r + 1'b1;
          rd_en     = 1'b1;
          rd_addr   = parent_node;
          node_nxt  = parent_node;
          state_nxt = ST_INS_WALK;
        end
      end
      ST_INS_WALK: begin
        wr_en = 1'b1;
        // root count lives in total_r, stop below it
        if (node_r[VB:1] == NODE_ONE) begin
          state_nxt = ST_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = parent_node;
          node_nxt = parent_node;
        end
      end
      ST_Q_WALK: begin
        if (rd_data == '0) begin
          state_nxt = ST_DONE;
        end else begin
          // subtree full when its count reaches 2^lvl
          if (rd_data[lvl_r]) begin
            sel_node       = node_r ^ (VB+1)'(1);
            res_nxt[lvl_r] = 1'b1;
          end
          if (lvl_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = {sel_node[VB-1:0], mask_r[lvl_dec]};
            node_nxt = {sel_node[VB-1:0], mask_r[lvl_dec]};
            lvl_nxt  = lvl_dec;
          end
        end
      end
      ST_DONE: begin
        if (rsp_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ready = (state_r == ST_IDLE);

  always_comb begin
    rsp             = '0;
    rsp.valid       = (state_r == ST_DONE);
    rsp.mex[CW-1:0] = res_r[CW-1:0];
    rsp.all_present = full_r;
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr_en)
    else $error("tree write while idle");

  a_full_mex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && full_r) |-> (res_r == '0))
    else $error("full set reported with nonzero mex");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r[VB] |-> (total_r[VB-1:0] == '0))
    else $error("set size above value space");

  a_lvl_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Q_WALK && $past(state_r) == ST_Q_WALK) |->
      (lvl_r == $past(lvl_r) - 1'b1))
    else $error("descent skipped a level");

endmodule
`default_nettype wire

FILE: hw/rtl/xor_masked_mex_count_tree.sv
// Top level: stream ports, result register, count tree RAM and walker.
//
// Keeps a set of VALUE_BITS-bit values as a binary tree of subtree
// occupancy counts in one RAM (2^(VALUE_BITS+1) words of VALUE_BITS+1 bits).
// in_tuser = 0 inserts in_tdata into the set; in_tuser = 1 XORs in_tdata
// into a running mask and returns the smallest value m with m XOR mask not
// in the set (out_tuser = 1, mex 0, when the set is full). After reset a
// clearing pass writes every RAM word with in_tready low. The RAM is read
// at most once per tree level: an insert reads the leaf and climbs toward
// the root, a duplicate insert stops at the leaf, and a query descends
// until it reaches an empty subtree or a leaf, or skips the descent when
// the set is full; the result may then wait for a full output register.
// One transaction is worked at a time; a finished result waits in the
// output register while the next transaction is taken.
`default_nettype none
module xor_masked_mex_count_tree #(
  parameter int VALUE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] value
  input  wire logic        in_tuser,   // [0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [15:0] mex
  output logic             out_tuser   // [0] all_present
);
  import xmmct_pkg::*;

  localparam int AW = VALUE_BITS + 1;

  req_t           req;
  rsp_t           rsp;
  logic           ctrl_ready;
  logic           start;
  logic           rsp_take;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  rd_data;

  logic             out_valid_r, out_valid_nxt;
  logic [MEX_W-1:0] out_mex_r, out_mex_nxt;
  logic             out_full_r, out_full_nxt;

  assign req.cmd   = in_tuser;
  assign req.value = in_tdata;
  assign in_tready = ctrl_ready;
  assign start     = in_tvalid & ctrl_ready;
  // result slot free this cycle
  assign rsp_take  = !out_valid_r || out_tready;

  xmmct_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .ready    (ctrl_ready),
    .rsp      (rsp),
    .rsp_take (rsp_take),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  xmmct_ram #(
    .WIDTH(AW),
    .DEPTH(1 << AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_mex_nxt   = out_mex_r;
    out_full_nxt  = out_full_r;
    if (rsp.valid && rsp_take) begin
      out_valid_nxt = 1'b1;
      out_mex_nxt   = rsp.mex;
      out_full_nxt  = rsp.all_present;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mex_r  <= out_mex_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mex_r;
  assign out_tuser  = out_full_r;

endmodule
`default_nettype wire
